### rtl/ps2a_pkg.sv
// ---------------------------------------------------------------------------
// PS/2 ASCII decoder package
// Shared constants, types and the set-1 US keyboard lookup table.
// ---------------------------------------------------------------------------
package ps2a_pkg;

   localparam int unsigned DEF_RING_DEPTH = 256;
   localparam int unsigned CHAR_W         = 7;
   localparam int unsigned SCAN_W         = 8;

   localparam logic       OP_SCAN     = 1'b0;
   localparam logic       OP_READ     = 1'b1;
   localparam logic [7:0] PREFIX_EXT  = 8'hE0;
   localparam logic [6:0] LSHIFT_CODE = 7'h2A;
   localparam logic [6:0] RSHIFT_CODE = 7'h36;

   typedef struct packed {
      logic              ext;       // extended prefix flag after this word
      logic              shift;     // shift-held flag after this word
      logic              push_req;  // a character wants to enter the ring
      logic [CHAR_W-1:0] ch;
   } dec_out_type;

   // US layout, indexed by make codes 0x00 to 0x3F.
   function automatic logic [CHAR_W-1:0] ascii_lookup(input logic [5:0] code,
                                                      input logic       shift);
      logic [CHAR_W-1:0] ch;
      unique case (code)
         6'h01: ch = 7'h1B;
         6'h02: ch = shift ? 7'h21 : 7'h31;
         6'h03: ch = shift ? 7'h40 : 7'h32;
         6'h04: ch = shift ? 7'h23 : 7'h33;
         6'h05: ch = shift ? 7'h24 : 7'h34;
         6'h06: ch = shift ? 7'h25 : 7'h35;
         6'h07: ch = shift ? 7'h5E : 7'h36;
         6'h08: ch = shift ? 7'h26 : 7'h37;
         6'h09: ch = shift ? 7'h2A : 7'h38;
         6'h0A: ch = shift ? 7'h28 : 7'h39;
         6'h0B: ch = shift ? 7'h29 : 7'h30;
         6'h0C: ch = shift ? 7'h5F : 7'h2D;
         6'h0D: ch = shift ? 7'h2B : 7'h3D;
         6'h0E: ch = 7'h08;
         6'h0F: ch = 7'h09;
         6'h10: ch = shift ? 7'h51 : 7'h71;
         6'h11: ch = shift ? 7'h57 : 7'h77;
         6'h12: ch = shift ? 7'h45 : 7'h65;
         6'h13: ch = shift ? 7'h52 : 7'h72;
         6'h14: ch = shift ? 7'h54 : 7'h74;
         6'h15: ch = shift ? 7'h59 : 7'h79;
         6'h16: ch = shift ? 7'h55 : 7'h75;
         6'h17: ch = shift ? 7'h49 : 7'h69;
         6'h18: ch = shift ? 7'h4F : 7'h6F;
         6'h19: ch = shift ? 7'h50 : 7'h70;
         6'h1A: ch = shift ? 7'h7B : 7'h5B;
         6'h1B: ch = shift ? 7'h7D : 7'h5D;
         6'h1C: ch = 7'h0A;
         6'h1E: ch = shift ? 7'h41 : 7'h61;
         6'h1F: ch = shift ? 7'h53 : 7'h73;
         6'h20: ch = shift ? 7'h44 : 7'h64;
         6'h21: ch = shift ? 7'h46 : 7'h66;
         6'h22: ch = shift ? 7'h47 : 7'h67;
         6'h23: ch = shift ? 7'h48 : 7'h68;
         6'h24: ch = shift ? 7'h4A : 7'h6A;
         6'h25: ch = shift ? 7'h4B : 7'h6B;
         6'h26: ch = shift ? 7'h4C : 7'h6C;
         6'h27: ch = shift ? 7'h3A : 7'h3B;
         6'h28: ch = shift ? 7'h22 : 7'h27;
         6'h29: ch = shift ? 7'h7E : 7'h60;
         6'h2B: ch = shift ? 7'h7C : 7'h5C;
         6'h2C: ch = shift ? 7'h5A : 7'h7A;
         6'h2D: ch = shift ? 7'h58 : 7'h78;
         6'h2E: ch = shift ? 7'h43 : 7'h63;
         6'h2F: ch = shift ? 7'h56 : 7'h76;
         6'h30: ch = shift ? 7'h42 : 7'h62;
         6'h31: ch = shift ? 7'h4E : 7'h6E;
         6'h32: ch = shift ? 7'h4D : 7'h6D;
         6'h33: ch = shift ? 7'h3C : 7'h2C;
         6'h34: ch = shift ? 7'h3E : 7'h2E;
         6'h35: ch = shift ? 7'h3F : 7'h2F;
         6'h37: ch = 7'h2A;
         6'h39: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

### rtl/ps2a_ifs.sv
// ---------------------------------------------------------------------------
// PS/2 ASCII decoder channels
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
interface ps2a_req_if import ps2a_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [SCAN_W-1:0] scan_byte;

   modport source (output valid, opcode, scan_byte, input ready);
   modport sink   (input valid, opcode, scan_byte, output ready);
endinterface

interface ps2a_rsp_if import ps2a_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              char_valid;
   logic [CHAR_W-1:0] char_out;
   logic              dropped_full;
   logic              ring_not_empty;

   modport source (output valid, char_valid, char_out, dropped_full, ring_not_empty,
                   input ready);
   modport sink   (input valid, char_valid, char_out, dropped_full, ring_not_empty,
                   output ready);
endinterface

### rtl/ps2a_decode.sv
// ---------------------------------------------------------------------------
// PS/2 set-1 byte decoder
// Tracks the extended prefix and shift keys and maps make codes to ASCII.
// ---------------------------------------------------------------------------
module ps2a_decode import ps2a_pkg::*; (
   input  logic [SCAN_W-1:0] scan_byte,
   input  logic              ext_ff,
   input  logic              shift_ff,
   output dec_out_type       dec
);

   logic       make;
   logic [6:0] code;

   assign make = ~scan_byte[7];
   assign code = scan_byte[6:0];

   always_comb begin
      dec          = '0;
      dec.ext      = 1'b0;
      dec.shift    = shift_ff;
      if (scan_byte == PREFIX_EXT) begin
         dec.ext = 1'b1;
      end else if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
         // Shift keys are honored even after an extended prefix.
         dec.shift = make;
      end else if (make && !ext_ff && !code[6]) begin
         dec.ch       = ascii_lookup(code[5:0], shift_ff);
         dec.push_req = (dec.ch != '0);
      end
   end

endmodule

### rtl/ps2_scancode_to_ascii_fifo.sv
// ---------------------------------------------------------------------------
// PS/2 scancode to ASCII character ring
// Decodes set-1 scancode words into a character ring and serves read words.
// ---------------------------------------------------------------------------
// A request word is held in the input register until the response register
// can take it; its response word is then registered there.
// Throughput: one word per cycle while the consumer keeps ready high; the
// ring pointers update together with the response register, and the ring
// memory read is registered alongside the response.
// Reset (synchronous): flags and pointers clear, ring contents are left as is.
module ps2_scancode_to_ascii_fifo import ps2a_pkg::*; #(
   parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ps2a_req_if.sink   req_chan,
   ps2a_rsp_if.source rsp_chan
);

   localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   // Input register
   logic              s1_valid_ff;
   logic              s1_opcode_ff;
   logic [SCAN_W-1:0] s1_scan_ff;

   // Decoder and ring state
   logic             ext_ff, ext_in;
   logic             shift_ff, shift_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CHAR_W-1:0] ring_mem [RING_DEPTH];

   // Response register
   logic              out_valid_ff;
   logic              out_char_valid_ff, out_char_valid_in;
   logic              out_dropped_ff, out_dropped_in;
   logic              out_not_empty_ff, out_not_empty_in;
   logic [CHAR_W-1:0] rd_data_ff;

   dec_out_type      dec;
   logic             advance;
   logic             do_push;
   logic             do_pop;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;

   ps2a_decode u_decode (
      .scan_byte (s1_scan_ff),
      .ext_ff    (ext_ff),
      .shift_ff  (shift_ff),
      .dec       (dec)
   );

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      ext_in            = ext_ff;
      shift_in          = shift_ff;
      wr_ptr_in         = wr_ptr_ff;
      rd_ptr_in         = rd_ptr_ff;
      do_push           = 1'b0;
      do_pop            = 1'b0;
      out_char_valid_in = 1'b0;
      out_dropped_in    = 1'b0;
      if (advance) begin
         if (s1_opcode_ff == OP_SCAN) begin
            ext_in   = dec.ext;
            shift_in = dec.shift;
            if (dec.push_req) begin
               // One slot stays free so a full ring differs from an empty one.
               if (wr_next == rd_ptr_ff) begin
                  out_dropped_in = 1'b1;
               end else begin
                  do_push   = 1'b1;
                  wr_ptr_in = wr_next;
               end
            end
         end else if (wr_ptr_ff != rd_ptr_ff) begin
            do_pop            = 1'b1;
            out_char_valid_in = 1'b1;
            rd_ptr_in         = rd_next;
         end
      end
      out_not_empty_in = (wr_ptr_in != rd_ptr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         ext_ff           <= 1'b0;
         shift_ff         <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         out_char_valid_ff <= 1'b0;
         out_dropped_ff   <= 1'b0;
         out_not_empty_ff <= 1'b0;
      end else begin
         ext_ff    <= ext_in;
         shift_ff  <= shift_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff      <= 1'b1;
            out_char_valid_ff <= out_char_valid_in;
            out_dropped_ff    <= out_dropped_in;
            out_not_empty_ff  <= out_not_empty_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_opcode_ff <= req_chan.opcode;
         s1_scan_ff   <= req_chan.scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_mem[wr_ptr_ff] <= dec.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.char_valid     = out_char_valid_ff;
   assign rsp_chan.char_out       = out_char_valid_ff ? rd_data_ff : '0;
   assign rsp_chan.dropped_full   = out_dropped_ff;
   assign rsp_chan.ring_not_empty = out_not_empty_ff;

endmodule

### rtl/ps2a_checker.sv
// ---------------------------------------------------------------------------
// PS/2 ASCII decoder port checker
// Watches the response channel of the top level for consistent words.
// ---------------------------------------------------------------------------
module ps2a_checker import ps2a_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              char_valid,
   input logic [CHAR_W-1:0] char_out,
   input logic              dropped_full,
   input logic              ring_not_empty
);

   // A popped character is never zero, since zero codes are never queued.
   a_popped_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && char_valid |-> char_out != '0)
      else $error("popped character is zero");

   a_idle_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !char_valid |-> char_out == '0)
      else $error("character present without a pop");

   a_pop_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && char_valid |-> !dropped_full)
      else $error("read word reports a drop");

   // A drop only happens on a full ring, which cannot be empty.
   a_drop_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped_full |-> ring_not_empty)
      else $error("drop reported with an empty ring");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(char_valid)
         && $stable(char_out) && $stable(dropped_full) && $stable(ring_not_empty))
      else $error("response word changed while stalled");

endmodule

bind ps2_scancode_to_ascii_fifo ps2a_checker u_ps2a_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .char_valid     (rsp_chan.char_valid),
   .char_out       (rsp_chan.char_out),
   .dropped_full   (rsp_chan.dropped_full),
   .ring_not_empty (rsp_chan.ring_not_empty)
);

### test/ps2_scancode_to_ascii_fifo_checker.sv
// ---------------------------------------------------------------------------
// PS/2 scancode to ASCII ring checker
// Watches the request and response channels, keeps its own copy of the
// decoder flags and the character ring, and compares every response word
// field by field with the oldest predicted word.
// ---------------------------------------------------------------------------
module ps2_scancode_to_ascii_fifo_checker import ps2a_pkg::*; (
   input  logic clock,
   input  logic reset,
   ps2a_req_if  req_mon,
   ps2a_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   localparam int KEYMAP_SIZE = 64;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_out;
      logic              dropped_full;
      logic              ring_not_empty;
   } rsp_word_type;

   // US layout for make codes 0x00 to 0x3F; zero means the key has no character.
   byte unsigned keymap_base [KEYMAP_SIZE] = '{
      8'd0,  8'd27, "1",   "2",   "3",   "4",   "5",   "6",
      "7",   "8",   "9",   "0",   "-",   "=",   8'd8,  8'd9,
      "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
      "o",   "p",   "[",   "]",   8'd10, 8'd0,  "a",   "s",
      "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
      "'",   8'h60, 8'd0,  8'h5C, "z",   "x",   "c",   "v",
      "b",   "n",   "m",   ",",   ".",   "/",   8'd0,  "*",
      8'd0,  " ",   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
   };

   byte unsigned keymap_shift [KEYMAP_SIZE] = '{
      8'd0,  8'd27, "!",   "@",   "#",   "$",   "%",   "^",
      "&",   "*",   "(",   ")",   "_",   "+",   8'd8,  8'd9,
      "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
      "O",   "P",   "{",   "}",   8'd10, 8'd0,  "A",   "S",
      "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
      8'h22, "~",   8'd0,  "|",   "Z",   "X",   "C",   "V",
      "B",   "N",   "M",   "<",   ">",   "?",   8'd0,  "*",
      8'd0,  " ",   8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
   };

   bit                ext_armed  = 1'b0;
   bit                shift_down = 1'b0;
   logic [CHAR_W-1:0] char_fifo [$];
   rsp_word_type      awaited_rsp [$];
   int                mismatches = 0;
   int                rsp_seen   = 0;

   // Applies one request word to the flags and the ring, returns its response.
   function automatic rsp_word_type decode_and_serve(input logic op,
                                                     input logic [SCAN_W-1:0] sc);
      rsp_word_type      r;
      bit                was_ext;
      bit                is_make;
      logic [6:0]        code;
      logic [CHAR_W-1:0] ch;
      r = '0;
      if (op == OP_SCAN) begin
         if (sc == PREFIX_EXT) begin
            ext_armed = 1'b1;
         end else begin
            was_ext   = ext_armed;
            ext_armed = 1'b0;
            is_make   = !sc[7];
            code      = sc[6:0];
            // Shift keys are tracked even behind an extended prefix.
            if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
               shift_down = is_make;
            end else if (is_make && !was_ext && code < KEYMAP_SIZE) begin
               ch = shift_down ? keymap_shift[code[5:0]][CHAR_W-1:0]
                               : keymap_base[code[5:0]][CHAR_W-1:0];
               if (ch != '0) begin
                  if (char_fifo.size() < DEF_RING_DEPTH - 1) char_fifo.push_back(ch);
                  else r.dropped_full = 1'b1;
               end
            end
         end
      end else if (char_fifo.size() != 0) begin
         r.char_valid = 1'b1;
         r.char_out   = char_fifo.pop_front();
      end
      r.ring_not_empty = (char_fifo.size() != 0);
      return r;
   endfunction

   task automatic note_failure(input string what, input logic [7:0] want,
                               input logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("response word %0d: %s expected %h, got %h", rsp_seen, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         ext_armed  = 1'b0;
         shift_down = 1'b0;
         char_fifo.delete();
         awaited_rsp.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_rsp.size() == 0) begin
               note_failure("word with nothing outstanding, char_out", 8'h00,
                            {1'b0, rsp_mon.char_out});
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_mon.char_valid !== want.char_valid)
                  note_failure("char_valid", {7'b0, want.char_valid},
                               {7'b0, rsp_mon.char_valid});
               if (rsp_mon.char_out !== want.char_out)
                  note_failure("char_out", {1'b0, want.char_out}, {1'b0, rsp_mon.char_out});
               if (rsp_mon.dropped_full !== want.dropped_full)
                  note_failure("dropped_full", {7'b0, want.dropped_full},
                               {7'b0, rsp_mon.dropped_full});
               if (rsp_mon.ring_not_empty !== want.ring_not_empty)
                  note_failure("ring_not_empty", {7'b0, want.ring_not_empty},
                               {7'b0, rsp_mon.ring_not_empty});
            end
            rsp_seen++;
         end
         if (req_mon.valid && req_mon.ready)
            awaited_rsp.push_back(decode_and_serve(req_mon.opcode, req_mon.scan_byte));
      end
      pending_words <= awaited_rsp.size();
      fail_count    <= mismatches;
   end

endmodule

### test/ps2_scancode_to_ascii_fifo_tb.sv
// ---------------------------------------------------------------------------
// PS/2 scancode to ASCII ring testbench
// Drives scancode and read words in bursts against a stalling consumer,
// starting with hand-picked key sequences and then random typing, noise and
// reads; a separate checker predicts and compares every response word.
// ---------------------------------------------------------------------------
module ps2_scancode_to_ascii_fifo_tb;
   import ps2a_pkg::*;

   localparam int ITEM_TARGET      = 1950;
   localparam int LIMIT_CYCLES     = 200000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam int FILL_PHASE       = 1;
   localparam int HOLD_PHASE       = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_words;
   int   words_sent    = 0;
   int   burst_left    = 0;
   int   cycle_count   = 0;
   bit   long_hold_req = 1'b0;

   ps2a_req_if req_if ();
   ps2a_rsp_if rsp_if ();

   ps2_scancode_to_ascii_fifo dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   ps2_scancode_to_ascii_fifo_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one word, opening a new burst after a random gap when the old one is used up.
   task automatic send_word(input logic op, input logic [SCAN_W-1:0] sc);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.scan_byte <= sc;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      words_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // One key press: plain with typematic repeats, under shift, or behind the
   // extended prefix. A few codes lie above the mapped range.
   task automatic type_key();
      logic [6:0] code;
      logic [6:0] shift_key;
      int         repeats;
      code      = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(64, 127))
                                              : 7'($urandom_range(0, 63));
      shift_key = ($urandom_range(0, 1) == 1) ? LSHIFT_CODE : RSHIFT_CODE;
      repeats   = $urandom_range(1, 4);
      case ($urandom_range(0, 9)) inside
         0: begin
            send_word(OP_SCAN, PREFIX_EXT);
            send_word(OP_SCAN, {1'b0, code});
            send_word(OP_SCAN, PREFIX_EXT);
            send_word(OP_SCAN, {1'b1, code});
         end
         [1:3]: begin
            send_word(OP_SCAN, {1'b0, shift_key});
            repeat (repeats) send_word(OP_SCAN, {1'b0, code});
            send_word(OP_SCAN, {1'b1, code});
            send_word(OP_SCAN, {1'b1, shift_key});
         end
         default: begin
            repeat (repeats) send_word(OP_SCAN, {1'b0, code});
            send_word(OP_SCAN, {1'b1, code});
         end
      endcase
   endtask

   // Consumer side: changing ready patterns, plus one long hold-off on request.
   initial begin
      int hold_left;
      int span_left;
      int pattern;
      int tick;
      hold_left     = 0;
      span_left     = 0;
      pattern       = 0;
      tick          = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES;
         end
         if (span_left == 0) begin
            pattern   = $urandom_range(0, 3);
            span_left = $urandom_range(16, 160);
         end
         span_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_if.ready <= ((tick % 5) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [8:0] opening [$];
      int         phase;
      int         phase_len;
      int         read_pct;
      int         stop_at;
      int         roll;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_SCAN;
      req_if.scan_byte = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Read of an empty ring, repeated and extended prefixes, extended shift,
      // both shift keys, unmapped and out-of-table codes, stray break codes.
      opening = '{
         {OP_READ, 8'hFF},
         {OP_SCAN, PREFIX_EXT}, {OP_SCAN, PREFIX_EXT}, {OP_SCAN, 8'h1E},
         {OP_SCAN, PREFIX_EXT}, {OP_SCAN, 8'h2A}, {OP_SCAN, 8'h1E},
         {OP_SCAN, PREFIX_EXT}, {OP_SCAN, 8'hAA}, {OP_SCAN, 8'h1E},
         {OP_SCAN, 8'h36}, {OP_SCAN, 8'h02}, {OP_SCAN, 8'hB6},
         {OP_SCAN, 8'h00}, {OP_SCAN, 8'h3F}, {OP_SCAN, 8'h40}, {OP_SCAN, 8'h7F},
         {OP_SCAN, 8'hFF}, {OP_SCAN, 8'h80}, {OP_SCAN, 8'h9E},
         {OP_SCAN, 8'h39}, {OP_SCAN, 8'h01},
         {OP_READ, 8'h00}, {OP_READ, 8'h55}, {OP_READ, 8'hAA},
         {OP_READ, 8'h0F}, {OP_READ, 8'hF0}, {OP_READ, 8'h00}
      };
      foreach (opening[i]) send_word(opening[i][8], opening[i][7:0]);
      wait_for_drain();

      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         phase_len = $urandom_range(60, 250);
         case ($urandom_range(0, 3))
            0: read_pct = 2;
            1: read_pct = 25;
            2: read_pct = 50;
            default: read_pct = 85;
         endcase
         // An early typing run long enough to overflow the ring.
         if (phase == FILL_PHASE) begin
            phase_len = 900;
            read_pct  = 0;
         end
         if (phase == HOLD_PHASE) begin
            phase_len     = 300;
            long_hold_req = 1'b1;
         end
         stop_at = words_sent + phase_len;
         while (words_sent < stop_at && words_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < read_pct)
               send_word(OP_READ, 8'($urandom_range(0, 255)));
            else if (roll < read_pct + 8)
               send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else
               type_key();
         end
         if ($urandom_range(0, 2) == 0) wait_for_drain();
         phase++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
